>>> rtl/atp_pkg.sv
`default_nettype none
package atp_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int ANGLE_ENTRIES = 24;

    // x*x + z*z fits in 2*SAMPLE_BITS unsigned bits
    localparam int SUM_W     = 2 * SAMPLE_BITS;
    // root of (sum << 16): one digit per stage
    localparam int ROOT_BITS = SAMPLE_BITS + 8;
    localparam int REM_W     = ROOT_BITS + 2;
    localparam int CW        = SAMPLE_BITS + 28;
    localparam int ZW        = 26;
    localparam int PITCH_W   = 17;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    localparam logic signed [PITCH_W-1:0] ERROR_PITCH = -17'sd50944;
    localparam logic signed [PITCH_W-1:0] RIGHT_ANGLE = 17'sd23040;

    typedef struct packed {
        logic                          err;
        logic                          zero;
        logic signed [SAMPLE_BITS-1:0] y;
    } atp_meta_t;

    typedef struct packed {
        atp_meta_t         meta;
        logic [SUM_W-1:0]  sum;
    } atp_item_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic signed [ZW-1:0] atan_q16(input int idx);
        logic signed [ZW-1:0] a;
        begin
            case (idx)
                0:       a = 26'sd2949120;
                1:       a = 26'sd1740967;
                2:       a = 26'sd919879;
                3:       a = 26'sd466945;
                4:       a = 26'sd234379;
                5:       a = 26'sd117304;
                6:       a = 26'sd58666;
                7:       a = 26'sd29335;
                8:       a = 26'sd14668;
                9:       a = 26'sd7334;
                10:      a = 26'sd3667;
                11:      a = 26'sd1833;
                12:      a = 26'sd917;
                13:      a = 26'sd458;
                14:      a = 26'sd229;
                15:      a = 26'sd115;
                16:      a = 26'sd57;
                17:      a = 26'sd29;
                18:      a = 26'sd14;
                19:      a = 26'sd7;
                20:      a = 26'sd4;
                21:      a = 26'sd2;
                22:      a = 26'sd1;
                default: a = 26'sd0;
            endcase
            return a;
        end
    endfunction

endpackage
`default_nettype wire

>>> rtl/atp_front.sv
`default_nettype none
module atp_front (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    push,
    output logic                                         full,
    input  wire logic signed [atp_pkg::SAMPLE_BITS-1:0]  accel_x_raw,
    input  wire logic signed [atp_pkg::SAMPLE_BITS-1:0]  accel_y_raw,
    input  wire logic signed [atp_pkg::SAMPLE_BITS-1:0]  accel_z_raw,
    input  wire logic                                    read_failed,
    input  wire logic                                    q_full,
    output logic                                         q_push,
    output atp_pkg::atp_item_t                           q_data
);

    logic en;
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic signed [atp_pkg::SUM_W-1:0] xx_prod;
    logic signed [atp_pkg::SUM_W-1:0] zz_prod;
    logic [atp_pkg::SUM_W-1:0] xx_reg;
    logic [atp_pkg::SUM_W-1:0] zz_reg;
    logic [atp_pkg::SUM_W-1:0] sum_reg;
    atp_pkg::atp_meta_t meta1_next;
    atp_pkg::atp_meta_t meta1_reg;
    atp_pkg::atp_meta_t meta2_reg;

    assign en   = !q_full;
    assign full = q_full;

    assign xx_prod = accel_x_raw * accel_x_raw;
    assign zz_prod = accel_z_raw * accel_z_raw;

    always_comb
    begin
        meta1_next.err  = read_failed;
        meta1_next.zero = (accel_x_raw == '0) && (accel_z_raw == '0);
        meta1_next.y    = accel_y_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= push;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg    <= $unsigned(xx_prod);
            zz_reg    <= $unsigned(zz_prod);
            meta1_reg <= meta1_next;
            sum_reg   <= xx_reg + zz_reg;
            meta2_reg <= meta1_reg;
        end
    end

    assign q_push      = s2_valid_reg && en;
    assign q_data.meta = meta2_reg;
    assign q_data.sum  = sum_reg;

endmodule
`default_nettype wire

>>> rtl/atp_queue.sv
`default_nettype none
module atp_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                q_push,
    input  wire atp_pkg::atp_item_t  q_wdata,
    output logic                     q_full,
    input  wire logic                q_pop,
    output atp_pkg::atp_item_t       q_rdata,
    output logic                     q_empty
);

    atp_pkg::atp_item_t mem [atp_pkg::QDEPTH];
    logic [atp_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [atp_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [atp_pkg::QCNT_W-1:0] count_reg;

    assign q_full  = (count_reg == atp_pkg::QCNT_W'(atp_pkg::QDEPTH));
    assign q_empty = (count_reg == '0);
    assign q_rdata = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (q_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (q_push && !q_pop)
                count_reg <= count_reg + 1'b1;
            else if (q_pop && !q_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
            mem[wr_ptr_reg] <= q_wdata;
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= atp_pkg::QCNT_W'(atp_pkg::QDEPTH))
        else $error("queue count beyond depth");

    a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not rise on push");

    a_count_dec: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not fall on pop");

endmodule
`default_nettype wire

>>> rtl/atp_back.sv
`default_nettype none
module atp_back (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               q_empty,
    input  wire atp_pkg::atp_item_t                 q_data,
    output logic                                    q_pop,
    input  wire logic                               pop,
    output logic                                    empty,
    output logic signed [atp_pkg::PITCH_W-1:0]      pitch_degrees,
    output logic                                    angle_valid
);

    localparam int SQ  = atp_pkg::ROOT_BITS;
    localparam int CS  = atp_pkg::CORDIC_STAGES;
    localparam int NST = SQ + CS + 2;
    localparam int CW  = atp_pkg::CW;
    localparam int ZW  = atp_pkg::ZW;
    localparam int RB  = atp_pkg::ROOT_BITS;
    localparam int SB  = atp_pkg::SAMPLE_BITS;
    localparam int PW  = atp_pkg::PITCH_W;
    localparam logic signed [ZW:0] RA_WIDE = (ZW+1)'(atp_pkg::RIGHT_ANGLE);

    logic en;
    logic [NST-1:0] v_reg;
    logic out_valid_reg;

    logic [atp_pkg::SUM_W-1:0]   sum_reg  [SQ+1];
    logic [atp_pkg::REM_W-1:0]   rem_reg  [SQ+1];
    logic [RB-1:0]               root_reg [SQ+1];
    atp_pkg::atp_meta_t          msq_reg  [SQ+1];
    logic [atp_pkg::REM_W-1:0]   rem_next  [SQ+1];
    logic [RB-1:0]               root_next [SQ+1];

    logic signed [CW-1:0]        cx_reg [CS+1];
    logic signed [CW-1:0]        cy_reg [CS+1];
    logic signed [ZW-1:0]        cz_reg [CS+1];
    atp_pkg::atp_meta_t          mc_reg [CS+1];
    logic signed [CW-1:0]        cx_next [CS+1];
    logic signed [CW-1:0]        cy_next [CS+1];
    logic signed [ZW-1:0]        cz_next [CS+1];

    logic signed [ZW:0]          zr;
    logic signed [ZW:0]          p_full;
    logic signed [PW-1:0]        pitch_next;
    logic                        valid_next;
    logic signed [PW-1:0]        pitch_reg;
    logic                        angle_valid_reg;
    atp_pkg::atp_meta_t          mfin;

    assign en    = !out_valid_reg || pop;
    assign q_pop = en && !q_empty;
    assign empty = !out_valid_reg;

    // restoring square root, one root bit per stage
    always_comb
    begin
        logic [2*RB-1:0]            rad;
        logic [atp_pkg::REM_W-1:0]  trial;
        logic [atp_pkg::REM_W-1:0]  t;
        rem_next[0]  = '0;
        root_next[0] = '0;
        for (int j = 1; j <= SQ; j++)
        begin
            rad   = {sum_reg[j-1], 16'b0};
            trial = {rem_reg[j-1][atp_pkg::REM_W-3:0], rad[2*(SQ-j)+1 -: 2]};
            t     = {root_reg[j-1], 2'b01};
            if (trial >= t)
            begin
                rem_next[j]  = trial - t;
                root_next[j] = {root_reg[j-1][RB-2:0], 1'b1};
            end
            else
            begin
                rem_next[j]  = trial;
                root_next[j] = {root_reg[j-1][RB-2:0], 1'b0};
            end
        end
    end

    // vectoring CORDIC, shifts floor toward minus infinity
    always_comb
    begin
        cx_next[0] = '0;
        cy_next[0] = '0;
        cz_next[0] = '0;
        for (int i = 0; i < CS; i++)
        begin
            if (!cy_reg[i][CW-1])
            begin
                cx_next[i+1] = cx_reg[i] + (cy_reg[i] >>> i);
                cy_next[i+1] = cy_reg[i] - (cx_reg[i] >>> i);
                cz_next[i+1] = cz_reg[i] + atp_pkg::atan_q16(i);
            end
            else
            begin
                cx_next[i+1] = cx_reg[i] - (cy_reg[i] >>> i);
                cy_next[i+1] = cy_reg[i] + (cx_reg[i] >>> i);
                cz_next[i+1] = cz_reg[i] - atp_pkg::atan_q16(i);
            end
        end
    end

    always_comb
    begin
        mfin   = mc_reg[CS];
        zr     = (ZW+1)'(128) - {cz_reg[CS][ZW-1], cz_reg[CS]};
        p_full = zr >>> 8;
        valid_next = 1'b1;
        if (mfin.err)
        begin
            pitch_next = atp_pkg::ERROR_PITCH;
            valid_next = 1'b0;
        end
        else if (mfin.zero)
        begin
            if (mfin.y > 0)
                pitch_next = -atp_pkg::RIGHT_ANGLE;
            else if (mfin.y < 0)
                pitch_next = atp_pkg::RIGHT_ANGLE;
            else
                pitch_next = '0;
        end
        else if (p_full > RA_WIDE)
            pitch_next = atp_pkg::RIGHT_ANGLE;
        else if (p_full < -RA_WIDE)
            pitch_next = -atp_pkg::RIGHT_ANGLE;
        else
            pitch_next = p_full[PW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[NST-2:0], q_pop};
            out_valid_reg <= v_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sum_reg[0]  <= q_data.sum;
            msq_reg[0]  <= q_data.meta;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            for (int j = 1; j <= SQ; j++)
            begin
                sum_reg[j]  <= sum_reg[j-1];
                msq_reg[j]  <= msq_reg[j-1];
                rem_reg[j]  <= rem_next[j];
                root_reg[j] <= root_next[j];
            end
            cx_reg[0] <= $signed({{(CW-RB-16){1'b0}}, root_reg[SQ], 16'b0});
            cy_reg[0] <= $signed({{(CW-SB-24){msq_reg[SQ].y[SB-1]}}, msq_reg[SQ].y, 24'b0});
            cz_reg[0] <= '0;
            mc_reg[0] <= msq_reg[SQ];
            for (int i = 1; i <= CS; i++)
            begin
                cx_reg[i] <= cx_next[i];
                cy_reg[i] <= cy_next[i];
                cz_reg[i] <= cz_next[i];
                mc_reg[i] <= mc_reg[i-1];
            end
            pitch_reg       <= pitch_next;
            angle_valid_reg <= valid_next;
        end
    end

    assign pitch_degrees = pitch_reg;
    assign angle_valid   = angle_valid_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v_reg) && out_valid_reg)
        else $error("pipeline moved while stalled");

    a_pop_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty && en)
        else $error("queue read without room");

endmodule
`default_nettype wire

>>> rtl/accel_tilt_pitch_core.sv
// Pitch angle from three accelerometer samples, square root then CORDIC.
// A sample passes the front stages, the queue, the root and CORDIC stages and the output register.
// Throughput: one transaction per cycle when nothing stalls; the root and CORDIC pipelines
// advance together whenever the output register is free or being popped.
// Reset (rst_n, asynchronous): pipelines, queue and output come up empty.
`default_nettype none
module accel_tilt_pitch_core (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    push,
    output logic                                         full,
    input  wire logic signed [atp_pkg::SAMPLE_BITS-1:0]  accel_x_raw,
    input  wire logic signed [atp_pkg::SAMPLE_BITS-1:0]  accel_y_raw,
    input  wire logic signed [atp_pkg::SAMPLE_BITS-1:0]  accel_z_raw,
    input  wire logic                                    read_failed,
    output logic                                         empty,
    input  wire logic                                    pop,
    output logic signed [atp_pkg::PITCH_W-1:0]           pitch_degrees,
    output logic                                         angle_valid
);

    logic               q_full;
    logic               q_push;
    logic               q_pop;
    logic               q_empty;
    atp_pkg::atp_item_t q_wdata;
    atp_pkg::atp_item_t q_rdata;

    atp_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .accel_x_raw (accel_x_raw),
        .accel_y_raw (accel_y_raw),
        .accel_z_raw (accel_z_raw),
        .read_failed (read_failed),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_wdata)
    );

    atp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_push  (q_push),
        .q_wdata (q_wdata),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_rdata (q_rdata),
        .q_empty (q_empty)
    );

    atp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_rdata),
        .q_pop         (q_pop),
        .pop           (pop),
        .empty         (empty),
        .pitch_degrees (pitch_degrees),
        .angle_valid   (angle_valid)
    );

endmodule
`default_nettype wire

>>> dv/tb_accel_tilt_pitch_core.sv
`default_nettype none
module tb_accel_tilt_pitch_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_CYCLES = 20000;
    localparam int DRAIN_CYCLES    = 100;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic signed [atp_pkg::SAMPLE_BITS-1:0] accel_x_raw = '0;
    logic signed [atp_pkg::SAMPLE_BITS-1:0] accel_y_raw = '0;
    logic signed [atp_pkg::SAMPLE_BITS-1:0] accel_z_raw = '0;
    logic read_failed = 1'b0;
    logic signed [atp_pkg::PITCH_W-1:0] pitch_degrees;
    logic angle_valid;

    typedef struct {
        logic signed [atp_pkg::PITCH_W-1:0] pitch;
        logic                               valid;
    } pitch_result_t;

    pitch_result_t pitch_q[$];
    int  fail_count = 0;
    int  idle_cycles = 0;
    bit  sink_quiet = 1'b0;     // no pop idling while set
    bit  sink_hold = 1'b0;      // long receiver stall
    bit  src_quiet = 1'b0;

    accel_tilt_pitch_core i_dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .accel_x_raw(accel_x_raw), .accel_y_raw(accel_y_raw),
        .accel_z_raw(accel_z_raw), .read_failed(read_failed),
        .empty(empty), .pop(pop),
        .pitch_degrees(pitch_degrees), .angle_valid(angle_valid)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint asr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint isqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end
            else
                root >>= 1;
            bitv >>= 2;
        end
        return longint'(root);
    endfunction

    function automatic pitch_result_t predict_pitch(logic signed [15:0] ax,
                                                    logic signed [15:0] ay,
                                                    logic signed [15:0] az,
                                                    logic fail);
        pitch_result_t r;
        longint x, y, z, p, cx, cy, cz, nx, ny, d;
        longint atan_tab[24];
        atan_tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
                     14668, 7334, 3667, 1833, 917, 458, 229, 115,
                     57, 29, 14, 7, 4, 2, 1, 0};
        r.valid = 1'b1;
        if (fail)
        begin
            r.pitch = atp_pkg::ERROR_PITCH;
            r.valid = 1'b0;
            return r;
        end
        x = ax;
        y = ay;
        z = az;
        if (x == 0 && z == 0)
            p = (y > 0) ? -23040 : ((y < 0) ? 23040 : 0);
        else
        begin
            d = isqrt(longint'(x * x + z * z) << 16);
            cx = d * 65536;
            cy = y * 16777216;
            cz = 0;
            for (int i = 0; i < atp_pkg::CORDIC_STAGES && i < 24; i++)
            begin
                if (cy >= 0)
                begin
                    nx = cx + asr_floor(cy, i);
                    ny = cy - asr_floor(cx, i);
                    cz += atan_tab[i];
                end
                else
                begin
                    nx = cx - asr_floor(cy, i);
                    ny = cy + asr_floor(cx, i);
                    cz -= atan_tab[i];
                end
                cx = nx;
                cy = ny;
            end
            p = asr_floor(-cz + 128, 8);
            if (p > 23040) p = 23040;
            if (p < -23040) p = -23040;
        end
        r.pitch = p[atp_pkg::PITCH_W-1:0];
        return r;
    endfunction

    // one transaction into the block; returns after acceptance with push still high
    task automatic send_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                               logic signed [15:0] az, logic fail);
        while (!src_quiet && $urandom_range(99) < 17)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        accel_x_raw <= ax;
        accel_y_raw <= ay;
        accel_z_raw <= az;
        read_failed <= fail;
        @(posedge clk);
        while (full)
            @(posedge clk);
        pitch_q.push_back(predict_pitch(ax, ay, az, fail));
    endtask

    // drop push after the last transaction of a burst
    task automatic end_burst();
        push <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'(int'($urandom_range(8)) - 4);
            1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic wait_drained();
        while (pitch_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic signed [15:0] ext[5];
        ext = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001, 16'shffff};
        send_sample(16'sh1234, 16'sh0567, 16'sh7fff, 1'b1);
        send_sample(16'sh0000, 16'sh0000, 16'sh0000, 1'b0);
        send_sample(16'sh0000, 16'sh7fff, 16'sh0000, 1'b0);
        send_sample(16'sh0000, 16'sh8000, 16'sh0000, 1'b0);
        send_sample(16'sh0000, 16'sh0001, 16'sh0000, 1'b0);
        send_sample(16'sh0000, 16'shffff, 16'sh0000, 1'b0);
        for (int i = 0; i < 5; i++)
            send_sample(ext[i], ext[(i + 2) % 5], ext[(i + 1) % 5], 1'b0);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 1'b0);
        send_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
        send_sample(16'sh0001, 16'sh8000, 16'sh0000, 1'b0);
        send_sample(16'sh0000, 16'sh7fff, 16'shffff, 1'b0);
        send_sample(16'sh8000, 16'sh0001, 16'sh0000, 1'b0);
        send_sample(16'sh7fff, 16'sh0000, 16'sh8000, 1'b0);
        send_sample(16'shffff, 16'shffff, 16'sh0000, 1'b1);
        end_burst();
    endtask

    task automatic test_random(int count);
        for (int n = 0; n < count; n++)
            send_sample(rand_sample(), rand_sample(), rand_sample(),
                        $urandom_range(15) == 0);
        end_burst();
    endtask

    task automatic test_no_idling(int count);
        src_quiet = 1'b1;
        sink_quiet = 1'b1;
        test_random(count);
        src_quiet = 1'b0;
        sink_quiet = 1'b0;
    endtask

    // receiver stalls while the sender keeps pushing, filling the pipeline
    task automatic test_backpressure();
        sink_hold = 1'b1;
        fork
            test_random(120);
            begin
                repeat (300) @(posedge clk);
                sink_hold = 1'b0;
            end
        join
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (pitch_q.size() == 0)
            begin
                $error("result with nothing expected: pitch %0d", pitch_degrees);
                fail_count++;
            end
            else
            begin
                pitch_result_t e;
                e = pitch_q.pop_front();
                if (pitch_degrees !== e.pitch)
                begin
                    $error("pitch_degrees expected %0d got %0d", e.pitch, pitch_degrees);
                    fail_count++;
                end
                if (angle_valid !== e.valid)
                begin
                    $error("angle_valid expected %0b got %0b", e.valid, angle_valid);
                    fail_count++;
                end
            end
        end
        if (rst_n)
            pop <= !sink_hold && (sink_quiet || $urandom_range(99) >= 17);
    end

    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("tb_accel_tilt_pitch_core NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(600);
        test_backpressure();
        // sender pauses until all transactions are back
        wait_drained();
        test_no_idling(300);
        test_random(680);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pitch_q.size() == 0)
            $display("tb_accel_tilt_pitch_core OK");
        else
            $display("tb_accel_tilt_pitch_core NOT OK");
        $finish;
    end
endmodule
`default_nettype wire
